[design/brv_pkg.sv]
// Package for the boot record validator: request types, verdict codes,
// register indexes, record layout constants and the byte-wide CRC-32 step.
// No dependencies.
`default_nettype none

package brv_pkg;

  // Record layout (byte positions, little endian fields)
  localparam int unsigned PosW        = 5;
  localparam logic [PosW-1:0] PosVersion  = 5'd4;
  localparam logic [PosW-1:0] PosReserved = 5'd6;
  localparam logic [PosW-1:0] PosSize     = 5'd8;
  localparam logic [PosW-1:0] PosCrc      = 5'd12;
  localparam logic [PosW-1:0] PosPayload  = 5'd16;
  localparam logic [PosW-1:0] PosLast     = 5'd19;
  localparam logic [PosW-1:0] RecLen      = 5'd20;

  localparam logic [31:0] PayloadBytes = 32'd4;

  // CRC-32 (reflected)
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [31:0] HeaderMagicRst = 32'h5453_5250;
  localparam logic [31:0] StayMarkerRst  = 32'hB007_107D;
  localparam logic [15:0] ExpVersionRst  = 16'd1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderMagic = 2'd0,
    CfgStayMarker  = 2'd1,
    CfgExpVersion  = 2'd2
  } cfg_idx_e;

  // Verdict codes
  typedef enum logic [2:0] {
    VerdictStay       = 3'd0,
    VerdictBadMagic   = 3'd1,
    VerdictBadVersion = 3'd2,
    VerdictBadSize    = 3'd3,
    VerdictCrcError   = 3'd4,
    VerdictOther      = 3'd5
  } verdict_e;

  // Input request: one record byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic       record_start;
  } in_req_t;

  // Output request: one verdict per record
  typedef struct packed {
    logic     stay;
    verdict_e verdict;
  } out_req_t;

  // One byte through the reflected CRC-32, bit at a time (eight xor levels)
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/boot_record_validator.sv]
// Boot record validator top level: byte parser, payload CRC and verdict.
// Depends on brv_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | in        | in_valid_i/in_ready_o   | in_req_i  (byte, record start)
//  out     | out       | out_valid_o/out_ready_i | out_req_o (stay, verdict)
//  cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle. The verdict is registered at the edge that
// takes byte 19 and is shown the next cycle in the output register.
// Input stalls only while that output register is full and not taken.
// Reset sets position 0, CRC all ones and the registers to their defaults.
`default_nettype none

module boot_record_validator
  import brv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_req_t             in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_req_t                 out_req_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i
);

  // Configuration registers
  logic [31:0] header_magic_q;
  logic [31:0] stay_marker_q;
  logic [15:0] exp_version_q;

  // Parser state
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     magic_q;
  logic [15:0]     version_q;
  logic [31:0]     size_q;
  logic [31:0]     stored_crc_q;
  logic [31:0]     payload_q;

  // Output register
  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q, out_req_d;

  logic            in_fire;
  logic [PosW-1:0] pos_eff;
  logic            pos_live;
  logic [31:0]     crc_in;
  logic [31:0]     crc_next;
  logic [31:0]     payload_full;
  verdict_e        verdict;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_magic_q <= HeaderMagicRst;
      stay_marker_q  <= StayMarkerRst;
      exp_version_q  <= ExpVersionRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeaderMagic: header_magic_q <= cfg_wdata_i;
        CfgStayMarker:  stay_marker_q  <= cfg_wdata_i;
        CfgExpVersion:  exp_version_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Position after a possible restart; bytes past the record are dropped
  assign pos_eff  = in_req_i.record_start ? '0 : pos_q;
  assign pos_live = pos_eff < RecLen;

  // CRC restarts at the first payload byte
  assign crc_in       = (pos_eff == PosPayload) ? CrcInit : crc_q;
  assign crc_next     = crc_byte(crc_in, in_req_i.byte_value);
  assign payload_full = {in_req_i.byte_value, payload_q[23:0]};

  // Verdict for the last byte, checked in priority order
  always_comb begin
    priority if (magic_q != header_magic_q)   verdict = VerdictBadMagic;
    else if (version_q != exp_version_q)      verdict = VerdictBadVersion;
    else if (size_q != PayloadBytes)          verdict = VerdictBadSize;
    else if (~crc_next != stored_crc_q)       verdict = VerdictCrcError;
    else if (payload_full != stay_marker_q)   verdict = VerdictOther;
    else                                      verdict = VerdictStay;
  end

  // Next state of position, CRC and output register
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_req_d   = out_req_q;
    if (in_fire) begin
      if (in_req_i.record_start) begin
        pos_d = '0;
        crc_d = CrcInit;
      end
      if (pos_live) begin
        pos_d = pos_eff + 1'b1;
        if (pos_eff >= PosPayload) begin
          crc_d = crc_next;
        end
        if (pos_eff == PosLast) begin
          out_valid_d       = 1'b1;
          out_req_d.stay    = (verdict == VerdictStay);
          out_req_d.verdict = verdict;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  // Field capture, one byte lane per accepted byte
  always_ff @(posedge clk_i) begin
    if (in_fire && pos_live) begin
      priority if (pos_eff < PosVersion) begin
        magic_q[8*pos_eff[1:0] +: 8] <= in_req_i.byte_value;
      end else if (pos_eff < PosReserved) begin
        version_q[8*pos_eff[0] +: 8] <= in_req_i.byte_value;
      end else if (pos_eff < PosSize) begin
        // reserved bytes are not kept
      end else if (pos_eff < PosCrc) begin
        size_q[8*pos_eff[1:0] +: 8] <= in_req_i.byte_value;
      end else if (pos_eff < PosPayload) begin
        stored_crc_q[8*pos_eff[1:0] +: 8] <= in_req_i.byte_value;
      end else begin
        payload_q[8*pos_eff[1:0] +: 8] <= in_req_i.byte_value;
      end
    end
  end

`ifndef SYNTHESIS
  // Position never runs past the end of the record
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= RecLen)
    else $error("byte position beyond record length");

  // A verdict appears only after the last record byte was taken
  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && pos_eff == PosLast))
    else $error("verdict without last record byte");

  // Taking the last byte leaves the parser at rest
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pos_eff == PosLast) |=> (pos_q == RecLen))
    else $error("parser not at rest after last byte");

  // Stay flag agrees with the verdict code
  a_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_req_q.stay == (out_req_q.verdict == VerdictStay)))
    else $error("stay flag disagrees with verdict");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for boot_record_validator: random 20-byte records,
// a byte-level verdict predictor and random idling on both channels.
// Depends on brv_pkg and the boot_record_validator RTL.
`timescale 1ns / 1ps

module testbench
  import brv_pkg::*;
;

  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 165;  // record bytes per register setting
  localparam int HoldCycles = 200;  // long receiver hold-off

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_req_t out_req_o;
  logic     cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CfgHeaderMagic;
  logic [31:0] cfg_wdata_i = '0;

  boot_record_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies used by the predictor and the record builder
  logic [31:0] want_magic   = HeaderMagicRst;
  logic [31:0] want_marker  = StayMarkerRst;
  logic [15:0] want_version = ExpVersionRst;

  // Parser state of the predictor
  logic [4:0]  rec_pos      = '0;
  logic [31:0] run_crc      = CrcInit;
  logic [31:0] seen_magic   = '0;
  logic [15:0] seen_version = '0;
  logic [31:0] seen_size    = '0;
  logic [31:0] seen_crc     = '0;
  logic [31:0] seen_payload = '0;

  in_req_t  pending[$];       // bytes waiting to be offered
  out_req_t verdicts_due[$];  // predicted verdicts, oldest first
  out_req_t due;

  int errors = 0;
  int cycle_count = 0;
  int bytes_taken = 0;
  int settings_run = 1;
  int verdict_hits[6] = '{default: 0};
  int send_gap = 0, send_calm = 0;
  int stall_left = 0, recv_calm = 0;
  int holds_asked = 0, holds_served = 0;

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Mostly no gap, some short, a few long; now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 90);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_shift8(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [31:0] payload_crc(input logic [31:0] word);
    logic [31:0] c;
    c = CrcInit;
    for (int k = 0; k < 4; k++) c = crc_shift8(c, word[8*k +: 8]);
    return ~c;
  endfunction

  // Predict the effect of one accepted request byte
  task automatic predict_byte(input in_req_t req);
    logic [4:0] p;
    verdict_e   v;
    out_req_t   r;
    if (req.record_start) begin
      rec_pos = '0;
      run_crc = CrcInit;
    end
    p = rec_pos;
    if (p >= RecLen) return;  // resting after a complete record
    if (p < PosVersion) seen_magic[8*p[1:0] +: 8] = req.byte_value;
    else if (p < PosReserved) seen_version[8*p[0] +: 8] = req.byte_value;
    else if (p < PosSize) ;   // reserved, not checked
    else if (p < PosCrc) seen_size[8*p[1:0] +: 8] = req.byte_value;
    else if (p < PosPayload) seen_crc[8*p[1:0] +: 8] = req.byte_value;
    else begin
      if (p == PosPayload) run_crc = CrcInit;
      seen_payload[8*p[1:0] +: 8] = req.byte_value;
      run_crc = crc_shift8(run_crc, req.byte_value);
    end
    rec_pos = p + 5'd1;
    if (p != PosLast) return;
    if (seen_magic != want_magic) v = VerdictBadMagic;
    else if (seen_version != want_version) v = VerdictBadVersion;
    else if (seen_size != PayloadBytes) v = VerdictBadSize;
    else if (~run_crc != seen_crc) v = VerdictCrcError;
    else if (seen_payload != want_marker) v = VerdictOther;
    else v = VerdictStay;
    r.stay    = (v == VerdictStay);
    r.verdict = v;
    verdicts_due.push_back(r);
  endtask

  // Nonzero flip pattern within the low w bits
  function automatic logic [31:0] flip_mask(input int w);
    logic [31:0] m;
    case ($urandom_range(0, 3))
      0, 1: m = 32'd1 << $urandom_range(0, w - 1);
      2: m = '1;
      default: m = $urandom;
    endcase
    if (w < 32) m &= (32'd1 << w) - 32'd1;
    if (m == 0) m = 32'd1;
    return m;
  endfunction

  // The targeted field fails; later-checked fields sometimes fail as well
  function automatic bit spoil(input int t, input int f);
    return (t == f) || (t != VerdictStay && t < f && $urandom_range(0, 99) < 30);
  endfunction

  task automatic make_record(input int t, output logic [159:0] rec);
    logic [31:0] magic, size, crc, payload;
    logic [15:0] ver, rsvd;
    magic   = want_magic;
    ver     = want_version;
    size    = PayloadBytes;
    payload = want_marker;
    rsvd    = 16'($urandom);
    if (t != VerdictStay && t != VerdictOther && $urandom_range(0, 1)) payload = $urandom;
    if (spoil(t, VerdictBadMagic)) magic ^= flip_mask(32);
    if (spoil(t, VerdictBadVersion)) ver ^= 16'(flip_mask(16));
    if (spoil(t, VerdictBadSize)) size ^= flip_mask(32);
    if (spoil(t, VerdictOther)) payload ^= flip_mask(32);
    crc = payload_crc(payload);
    if (spoil(t, VerdictCrcError)) crc ^= flip_mask(32);
    rec = {payload, crc, size, rsvd, ver, magic};
  endtask

  task automatic add_byte(input logic [7:0] b, input bit start);
    in_req_t req;
    req.byte_value   = b;
    req.record_start = start;
    pending.push_back(req);
  endtask

  // One record (or a broken one); returns the count of bytes the parser uses
  task automatic push_record(output int useful);
    logic [159:0] rec;
    int r, n, t;
    r = $urandom_range(0, 99);
    if (r < 90) begin
      if (r < 36) t = VerdictStay;
      else if (r < 54) t = VerdictOther;
      else if (r < 63) t = VerdictCrcError;
      else if (r < 72) t = VerdictBadSize;
      else if (r < 81) t = VerdictBadVersion;
      else t = VerdictBadMagic;
      make_record(t, rec);
      for (int i = 0; i < 20; i++) add_byte(rec[8*i +: 8], i == 0);
      useful = 20;
      // stray bytes after a full record are dropped by the block
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(8'($urandom), 1'b0);
      end
    end else if (r < 95) begin
      // cut short; the next record start throws it away
      make_record(VerdictStay, rec);
      n = $urandom_range(1, 19);
      for (int i = 0; i < n; i++) add_byte(rec[8*i +: 8], i == 0);
      useful = n;
    end else begin
      // garbage with scattered restarts
      for (int i = 0; i < 20; i++) add_byte(8'($urandom), i == 0 || $urandom_range(0, 19) == 0);
      useful = 20;
    end
  endtask

  task automatic fill_phase();
    int used, n;
    used = 0;
    while (used < PhaseBytes) begin
      push_record(n);
      used += n;
    end
  endtask

  // Idle: nothing queued or offered, no verdict owed, then a few spare cycles
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || verdicts_due.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgHeaderMagic: want_magic = val;
      CfgStayMarker:  want_marker = val;
      default:        want_version = val[15:0];
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] magic, input logic [31:0] marker,
                               input logic [15:0] version);
    write_reg(CfgHeaderMagic, magic);
    write_reg(CfgStayMarker, marker);
    write_reg(CfgExpVersion, {16'd0, version});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Driver: offer queued requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_byte(in_req_i);
        bytes_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending.pop_front();
          send_gap   = pick_gap(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        stall_left   = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  = pick_gap(recv_calm);
      end
    end
  end

  // Monitor: compare each verdict with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        report($sformatf("verdict %0d with none predicted", out_req_o.verdict));
      end else begin
        due = verdicts_due.pop_front();
        verdict_hits[due.verdict]++;
        if (out_req_o.stay !== due.stay)
          report($sformatf("stay %b, predicted %b", out_req_o.stay, due.stay));
        if (out_req_o.verdict !== due.verdict)
          report($sformatf("verdict %0d, predicted %0d", out_req_o.verdict, due.verdict));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout at cycle %0d, %0d verdicts still owed", cycle_count,
               verdicts_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [159:0] rec;
    // Directed: first record right after reset without a start flag,
    // checked against the reset register values
    make_record(VerdictStay, rec);
    for (int i = 0; i < 20; i++) add_byte(rec[8*i +: 8], 1'b0);
    // bytes past the end of a record are ignored
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    // partial record, dropped by the restart that opens the random part
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hA5, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    fill_phase();
    wait_drained();

    apply_setting(32'h0, 32'h0, 16'h0);
    fill_phase();
    wait_drained();

    // receiver holds off while bytes keep coming, so the input backs up
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    holds_asked++;
    fill_phase();
    wait_drained();

    apply_setting($urandom, $urandom, 16'($urandom));
    fill_phase();
    wait_drained();

    apply_setting($urandom, $urandom, 16'($urandom_range(0, 3)));
    fill_phase();
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("%0d bytes taken under %0d register settings", bytes_taken, settings_run);
    $display("verdicts stay %0d, magic %0d, version %0d, size %0d, crc %0d, other %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
             verdict_hits[4], verdict_hits[5]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[boot_record_validator.f]
design/brv_pkg.sv
design/boot_record_validator.sv
test/testbench.sv
